FILE: hw/rtl/rrft_pkg.sv
// Shared types, constants and ring helpers for the round-robin picker
// with failure timeout. No dependencies.
`default_nettype none

package rrft_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TIME_W      = 32;
    localparam int TMO_W       = 16;
    localparam int ECNT_W      = 5;
    localparam int CFG_W       = 16;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic              t_cfg_idx;

    localparam t_cfg_idx REG_ENTRY_COUNT     = 1'b0;
    localparam t_cfg_idx REG_DISABLE_TIMEOUT = 1'b1;

    typedef enum logic {
        TCU_ADD,
        TCU_CMP
    } t_tcu_op;

    typedef struct packed {
        t_time sum;
        logic  ge;
    } t_tcu_res;

    // Clamp the programmed count into 1..MAX_ENTRIES.
    function automatic t_cnt eff_count(logic [ECNT_W-1:0] c);
        if (c == '0) begin
            return CNT_W'(1);
        end else if (int'(c) > MAX_ENTRIES) begin
            return CNT_W'(MAX_ENTRIES);
        end
        return CNT_W'(c);
    endfunction

    // Advance one place around the ring; wrap to zero past the count.
    function automatic t_idx ring_next(t_idx idx, t_cnt count);
        t_cnt n;
        n = CNT_W'(idx) + CNT_W'(1);
        if (n >= count) begin
            return '0;
        end
        return IDX_W'(n);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rrft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rrft_tcu.sv
// Shared time unit: one 33-bit adder for the saturating deadline sum and
// the expiry compare. Depends on rrft_pkg.
`default_nettype none

module rrft_tcu (
    input  wire rrft_pkg::t_tcu_op  i_op,
    input  wire rrft_pkg::t_time    i_now,
    input  wire rrft_pkg::t_time    i_opnd,
    output rrft_pkg::t_tcu_res      o_res
);

    import rrft_pkg::*;

    t_time             b_eff;
    logic              cin;
    logic [TIME_W:0]   sum_w;

    // Subtract by inverting the operand and carrying in; carry out is now >= opnd.
    assign b_eff = (i_op == TCU_CMP) ? ~i_opnd : i_opnd;
    assign cin   = (i_op == TCU_CMP);
    assign sum_w = {1'b0, i_now} + {1'b0, b_eff} + {{TIME_W{1'b0}}, cin};

    assign o_res.ge  = sum_w[TIME_W];
    assign o_res.sum = sum_w[TIME_W] ? {TIME_W{1'b1}} : sum_w[TIME_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/round_robin_with_fail_timeout.sv
// Top level of the round-robin picker with failure timeout.
// Depends on rrft_pkg, rrft_ram and rrft_tcu.
`default_nettype none

// Usage
//   Input words are taken at a rising edge with start high and busy low.
//   i_kind selects a dispatch (0) or a failure report (1). Each word gives
//   exactly one result word, shown for one cycle with o_valid high; the
//   receiver takes it at the edge that ends that cycle and cannot stall.
//   The user writes registers via i_cfg_we / i_cfg_index / i_cfg_data, index
//   0 entry_count, index 1 disable_timeout, only while busy is low; unchecked.
// Timing
//   A dispatch walks the ring one entry per cycle through the shared time
//   compare, after the S_RD state primes the deadline RAM read. It visits
//   at most one entry more than the clamped entry_count. A failure report
//   passes through S_FAIL, uses the shared adder once and then raises
//   o_valid. start may be taken again in the cycle that shows the result.
// Reset
//   i_rst_n low clears the sequencer, last pick and all disabled marks and
//   loads entry_count 1 and disable_timeout 5. Deadlines are left as they
//   are: one is only read for an entry whose mark is set, and setting the
//   mark always writes it.
module round_robin_with_fail_timeout (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   i_kind,
    input  wire rrft_pkg::t_time        i_now_time,
    input  wire logic [3:0]             i_failed_entry,
    output logic                        o_valid,
    output logic [3:0]                  o_chosen_entry,
    output logic                        o_status,
    output logic                        o_exhausted,
    output logic                        o_reactivated,
    input  wire logic                   i_cfg_we,
    input  wire rrft_pkg::t_cfg_idx     i_cfg_index,
    input  wire logic [rrft_pkg::CFG_W-1:0] i_cfg_data
);

    import rrft_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_FAIL = 2'd3;

    // Configuration registers.
    logic [ECNT_W-1:0] r_entry_count;
    logic [TMO_W-1:0]  r_timeout;

    // Sequencer and per-item working state.
    logic [1:0]        r_state, n_state;
    t_idx              r_idx, n_idx;
    t_cnt              r_tries, n_tries;
    t_idx              r_last, n_last;
    t_time             r_now, n_now;
    logic [3:0]        r_fe, n_fe;
    logic [MAX_ENTRIES-1:0] r_mark, n_mark;

    // Result word.
    logic              r_valid, n_valid;
    logic [3:0]        r_chosen, n_chosen;
    logic              r_status, n_status;
    logic              r_exh, n_exh;
    logic              r_react, n_react;

    t_cnt              count;
    t_idx              next_idx;
    t_idx              fe_idx;
    logic              fe_known;

    t_tcu_op           tcu_op;
    t_time             tcu_opnd;
    t_tcu_res          tcu_res;

    logic              ram_we;
    t_idx              ram_raddr;
    t_time             ram_rdata;

    assign count    = eff_count(r_entry_count);
    assign next_idx = ring_next(r_idx, count);
    assign fe_idx   = IDX_W'(r_fe);
    assign fe_known = int'(r_fe) < int'(count);
    assign busy     = (r_state != S_IDLE);

    // Prime the read with the first entry, then keep one entry ahead.
    assign ram_raddr = (r_state == S_RD) ? r_idx : next_idx;
    assign ram_we    = (r_state == S_FAIL) && fe_known && !r_mark[fe_idx];

    assign tcu_op   = (r_state == S_FAIL) ? TCU_ADD : TCU_CMP;
    assign tcu_opnd = (r_state == S_FAIL) ? TIME_W'(r_timeout) : ram_rdata;

    rrft_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_ENTRIES)
    ) u_deadline (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (fe_idx),
        .i_wdata (tcu_res.sum),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rrft_tcu u_tcu (
        .i_op   (tcu_op),
        .i_now  (r_now),
        .i_opnd (tcu_opnd),
        .o_res  (tcu_res)
    );

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_tries  = r_tries;
        n_last   = r_last;
        n_now    = r_now;
        n_fe     = r_fe;
        n_mark   = r_mark;
        n_valid  = 1'b0;
        n_chosen = r_chosen;
        n_status = r_status;
        n_exh    = r_exh;
        n_react  = r_react;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_now   = i_now_time;
                    n_fe    = i_failed_entry;
                    n_idx   = ring_next(r_last, count);
                    n_tries = '0;
                    n_state = i_kind ? S_FAIL : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                // Settle on an enabled entry, an expired one, or force the
                // entry after the last pick once the whole ring was seen.
                priority if (!r_mark[r_idx]) begin
                    n_react = 1'b0;
                    n_exh   = 1'b0;
                    n_valid = 1'b1;
                end else if (tcu_res.ge) begin
                    n_mark[r_idx] = 1'b0;
                    n_react       = 1'b1;
                    n_exh         = 1'b0;
                    n_valid       = 1'b1;
                end else if (r_tries == count) begin
                    n_mark[r_idx] = 1'b0;
                    n_react       = 1'b1;
                    n_exh         = 1'b1;
                    n_valid       = 1'b1;
                end else begin
                    n_idx   = next_idx;
                    n_tries = r_tries + CNT_W'(1);
                end
                if (n_valid) begin
                    n_chosen = 4'(r_idx);
                    n_status = 1'b0;
                    n_last   = r_idx;
                    n_state  = S_IDLE;
                end
            end
            S_FAIL: begin
                // Unknown entries report an error; repeated failures hold.
                if (fe_known && !r_mark[fe_idx]) begin
                    n_mark[fe_idx] = 1'b1;
                end
                n_chosen = r_fe;
                n_status = !fe_known;
                n_exh    = 1'b0;
                n_react  = 1'b0;
                n_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_last        <= '0;
            r_mark        <= '0;
            r_valid       <= 1'b0;
            r_entry_count <= ECNT_W'(1);
            r_timeout     <= TMO_W'(5);
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_mark  <= n_mark;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ENTRY_COUNT:     r_entry_count <= i_cfg_data[ECNT_W-1:0];
                    REG_DISABLE_TIMEOUT: r_timeout     <= i_cfg_data[TMO_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_tries  <= n_tries;
        r_now    <= n_now;
        r_fe     <= n_fe;
        r_chosen <= n_chosen;
        r_status <= n_status;
        r_exh    <= n_exh;
        r_react  <= n_react;
    end

    assign o_valid        = r_valid;
    assign o_chosen_entry = r_chosen;
    assign o_status       = r_status;
    assign o_exhausted    = r_exh;
    assign o_reactivated  = r_react;

    // An accepted word always starts work on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    // A result only follows the final check or failure step.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_CHK || r_state == S_FAIL))
        else $error("result strobe without a finishing step");

    // A forced pick is always a re-enable, and an error result picks nothing.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((!o_exhausted || o_reactivated) &&
                     (!o_status || (!o_reactivated && !o_exhausted))))
        else $error("inconsistent result flags");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for round_robin_with_fail_timeout: a directed table, then
// random phases under several register settings, checked against a local model.
// Depends on rrft_pkg and the round_robin_with_fail_timeout RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rrft_pkg::*;

    localparam int STALL_LIMIT    = 2000; // cycles with no word moving either way
    localparam int PHASES         = 12;
    localparam int WORDS_PER_PASS = 142;

    typedef enum logic {
        KIND_DISPATCH = 1'b0,
        KIND_FAIL     = 1'b1
    } kind_e;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_UNKNOWN = 1'b1;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_op_e;

    // One result word as the block reports it.
    typedef struct packed {
        t_idx chosen;
        logic status;
        logic exhausted;
        logic reactivated;
    } decision_t;

    // One line of the directed table: either a word to send or a register write.
    typedef struct packed {
        row_op_e         op;
        kind_e           kind;
        t_time           now;
        t_idx            fe;
        logic            typed;
        decision_t       want;
        t_cfg_idx        reg_sel;
        logic [CFG_W-1:0] reg_val;
    } row_t;

    // Clock, reset and block ports.
    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic             busy;
    logic             i_kind         = 1'b0;
    t_time            i_now_time     = '0;
    logic [3:0]       i_failed_entry = '0;
    logic             o_valid;
    logic [3:0]       o_chosen_entry;
    logic             o_status;
    logic             o_exhausted;
    logic             o_reactivated;
    logic             i_cfg_we       = 1'b0;
    t_cfg_idx         i_cfg_index    = REG_ENTRY_COUNT;
    logic [CFG_W-1:0] i_cfg_data     = '0;

    // Local copy of the ring state and the registers.
    logic [ECNT_W-1:0] cfg_count   = ECNT_W'(1);
    logic [TMO_W-1:0]  cfg_timeout = TMO_W'(5);
    t_idx              last_pick   = '0;
    logic              entry_off   [MAX_ENTRIES];
    t_time             entry_until [MAX_ENTRIES];

    decision_t decisions_due[$];
    row_t      directed[$];

    // Set by the sender for the word it is offering: a hand-typed answer, if any.
    logic      hand_typed = 1'b0;
    decision_t hand_word  = '0;

    int fails       = 0;
    int stall_count = 0;
    int n_words     = 0;
    int n_dispatch  = 0;
    int n_forced    = 0;
    int n_reenabled = 0;
    int n_unknown   = 0;

    round_robin_with_fail_timeout u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_now_time     (i_now_time),
        .i_failed_entry (i_failed_entry),
        .o_valid        (o_valid),
        .o_chosen_entry (o_chosen_entry),
        .o_status       (o_status),
        .o_exhausted    (o_exhausted),
        .o_reactivated  (o_reactivated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clamp the programmed count the way the block reads it.
    function automatic int span_of(logic [ECNT_W-1:0] c);
        if (c == '0) begin
            return 1;
        end else if (int'(c) > MAX_ENTRIES) begin
            return MAX_ENTRIES;
        end
        return int'(c);
    endfunction

    // Work out the result word of one accepted word and advance the ring state.
    task automatic decide_ring(input kind_e kind, input t_time now, input t_idx fe,
                               output decision_t d);
        int          count;
        int          tries;
        t_idx        idx;
        logic        done;
        logic [32:0] sum;
        d     = '0;
        count = span_of(cfg_count);
        if (kind == KIND_DISPATCH) begin
            idx  = last_pick;
            done = 1'b0;
            // Walk forward from the entry after the last pick; at most count+1 steps.
            for (tries = 0; tries <= count && !done; tries++) begin
                idx = (int'(idx) + 1 >= count) ? '0 : idx + t_idx'(1);
                if (!entry_off[idx]) begin
                    done = 1'b1;
                end else if (now >= entry_until[idx]) begin
                    // Deadline passed: put the entry back in service.
                    entry_off[idx] = 1'b0;
                    d.reactivated  = 1'b1;
                    done           = 1'b1;
                end else if (tries == count) begin
                    // Whole ring down: force this one back and flag it.
                    entry_off[idx] = 1'b0;
                    d.reactivated  = 1'b1;
                    d.exhausted    = 1'b1;
                    done           = 1'b1;
                end
            end
            last_pick = idx;
            d.chosen  = idx;
        end else begin
            d.chosen = fe;
            if (int'(fe) >= count) begin
                d.status = ST_UNKNOWN;
            end else if (!entry_off[fe]) begin
                // Disable until now + timeout, pinned at the top of the time range.
                sum             = {1'b0, now} + 33'(cfg_timeout);
                entry_off[fe]   = 1'b1;
                entry_until[fe] = sum[32] ? '1 : sum[31:0];
            end
        end
    endtask

    // Monitor: check result words, then predict for the word taken at this edge.
    always @(posedge i_clk) begin
        decision_t head;
        decision_t pred;
        logic      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                moved = 1'b1;
                if (decisions_due.size() == 0) begin
                    $error("result word with nothing pending: chosen_entry %0d",
                           o_chosen_entry);
                    fails++;
                end else begin
                    head = decisions_due.pop_front();
                    if (o_chosen_entry !== head.chosen) begin
                        $error("chosen_entry: expected %0d, got %0d",
                               head.chosen, o_chosen_entry);
                        fails++;
                    end
                    if (o_status !== head.status) begin
                        $error("status: expected %0d, got %0d", head.status, o_status);
                        fails++;
                    end
                    if (o_exhausted !== head.exhausted) begin
                        $error("exhausted: expected %0d, got %0d",
                               head.exhausted, o_exhausted);
                        fails++;
                    end
                    if (o_reactivated !== head.reactivated) begin
                        $error("reactivated: expected %0d, got %0d",
                               head.reactivated, o_reactivated);
                        fails++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                moved = 1'b1;
                decide_ring(kind_e'(i_kind), i_now_time, i_failed_entry, pred);
                // Hand-typed rows override the model's answer but still move its state.
                if (hand_typed) begin
                    pred = hand_word;
                end
                decisions_due.push_back(pred);
                n_words++;
                if (i_kind == KIND_DISPATCH) n_dispatch++;
                if (pred.exhausted)          n_forced++;
                if (pred.reactivated)        n_reenabled++;
                if (pred.status == ST_UNKNOWN) n_unknown++;
            end
            // Watchdog: drop the run if nothing moves for too long.
            stall_count = moved ? 0 : stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $error("watchdog: no word accepted or returned for %0d cycles",
                       STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input kind_e kind, input t_time now, input t_idx fe,
                             input logic typed, input decision_t want);
        @(negedge i_clk);
        start          <= 1'b1;
        i_kind         <= kind;
        i_now_time     <= now;
        i_failed_entry <= fe;
        hand_typed      = typed;
        hand_word       = want;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
    endtask

    // Drop start and wait until every pending result word has come back.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (decisions_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    // Write one register (block idle) and mirror it in the local copy.
    task automatic write_reg(input t_cfg_idx which, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        if (which == REG_ENTRY_COUNT) begin
            cfg_count = value[ECNT_W-1:0];
        end else begin
            cfg_timeout = value[TMO_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic row_t word_row(kind_e kind, t_time now, t_idx fe);
        row_t r;
        r      = '0;
        r.op   = ROW_WORD;
        r.kind = kind;
        r.now  = now;
        r.fe   = fe;
        return r;
    endfunction

    function automatic row_t typed_row(kind_e kind, t_time now, t_idx fe, t_idx chosen,
                                       logic status, logic exh, logic react);
        row_t r;
        r       = word_row(kind, now, fe);
        r.typed = 1'b1;
        r.want  = '{chosen: chosen, status: status, exhausted: exh, reactivated: react};
        return r;
    endfunction

    function automatic row_t cfg_row(t_cfg_idx which, logic [CFG_W-1:0] value);
        row_t r;
        r         = '0;
        r.op      = ROW_CFG;
        r.reg_sel = which;
        r.reg_val = value;
        return r;
    endfunction

    initial begin
        int               phase;
        int               k;
        int               span;
        logic             quiet;
        logic [ECNT_W-1:0] cnt_val;
        logic [TMO_W-1:0] tmo_val;
        t_time            tick;
        t_time            step;
        t_time            now;
        t_idx             fe;
        kind_e            kind;

        for (k = 0; k < MAX_ENTRIES; k++) begin
            entry_off[k]   = 1'b0;
            entry_until[k] = '0;
        end

        // Directed table. Reset values apply first: one entry, timeout 5.
        directed.push_back(typed_row(KIND_DISPATCH, 32'd0, 4'd0, 4'd0, ST_OK, 1'b0, 1'b0));
        // Unknown entry: index at or above the count.
        directed.push_back(typed_row(KIND_FAIL, 32'd0, 4'd15, 4'd15, ST_UNKNOWN, 1'b0, 1'b0));
        directed.push_back(typed_row(KIND_FAIL, 32'd100, 4'd0, 4'd0, ST_OK, 1'b0, 1'b0));
        // Repeated failure leaves the deadline at 105.
        directed.push_back(typed_row(KIND_FAIL, 32'd0, 4'd0, 4'd0, ST_OK, 1'b0, 1'b0));
        // Only entry down and unexpired: forced back, flagged exhausted.
        directed.push_back(typed_row(KIND_DISPATCH, 32'd104, 4'd0, 4'd0, ST_OK, 1'b1, 1'b1));
        directed.push_back(typed_row(KIND_FAIL, 32'd200, 4'd0, 4'd0, ST_OK, 1'b0, 1'b0));
        // Deadline reached exactly: re-enabled by expiry.
        directed.push_back(typed_row(KIND_DISPATCH, 32'd205, 4'd0, 4'd0, ST_OK, 1'b0, 1'b1));
        directed.push_back(cfg_row(REG_ENTRY_COUNT, 16'd3));
        directed.push_back(cfg_row(REG_DISABLE_TIMEOUT, 16'hFFFF));
        directed.push_back(word_row(KIND_FAIL, 32'd1000, 4'd0));
        directed.push_back(word_row(KIND_FAIL, 32'd1000, 4'd1));
        // Deadline sum saturates at the top of the time range.
        directed.push_back(word_row(KIND_FAIL, 32'hFFFF_FFFF, 4'd2));
        directed.push_back(word_row(KIND_DISPATCH, 32'd0, 4'd0));
        directed.push_back(word_row(KIND_DISPATCH, 32'hFFFF_FFFF, 4'd0));
        directed.push_back(typed_row(KIND_FAIL, 32'd0, 4'd3, 4'd3, ST_UNKNOWN, 1'b0, 1'b0));
        // Count of zero acts as one; last pick now lies beyond the ring.
        directed.push_back(cfg_row(REG_ENTRY_COUNT, 16'd0));
        directed.push_back(word_row(KIND_DISPATCH, 32'd500, 4'd0));
        // Count above the maximum acts as the maximum; zero timeout.
        directed.push_back(cfg_row(REG_ENTRY_COUNT, 16'd31));
        directed.push_back(cfg_row(REG_DISABLE_TIMEOUT, 16'd0));
        directed.push_back(word_row(KIND_FAIL, 32'd7, 4'd15));
        directed.push_back(word_row(KIND_DISPATCH, 32'd6, 4'd0));
        directed.push_back(word_row(KIND_DISPATCH, 32'd7, 4'd0));
        directed.push_back(word_row(KIND_FAIL, 32'd0, 4'd10));
        directed.push_back(word_row(KIND_DISPATCH, 32'd0, 4'd0));

        // Hold reset, then release it once for the whole run.
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            if (directed[r].op == ROW_CFG) begin
                settle();
                write_reg(directed[r].reg_sel, directed[r].reg_val);
            end else begin
                send_word(directed[r].kind, directed[r].now, directed[r].fe,
                          directed[r].typed, directed[r].want);
            end
        end

        // Random phases: each drains, reprograms both registers, then runs a
        // mostly well-formed stream with time moving forward and a little noise.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    cnt_val = ECNT_W'(1);
                    tmo_val = '0;
                end
                1: begin
                    cnt_val = ECNT_W'(16);
                    tmo_val = '1;
                end
                2: begin
                    cnt_val = '0;
                    tmo_val = TMO_W'(12);
                end
                3: begin
                    cnt_val = '1;
                    tmo_val = TMO_W'($urandom_range(20, 80));
                end
                default: begin
                    cnt_val = ($urandom_range(9) == 0) ? ECNT_W'($urandom_range(17, 31))
                                                       : ECNT_W'($urandom_range(1, 16));
                    k = $urandom_range(9);
                    if (k < 6) begin
                        tmo_val = TMO_W'($urandom_range(1, 60));
                    end else if (k < 8) begin
                        tmo_val = TMO_W'($urandom_range(0, 3));
                    end else begin
                        tmo_val = TMO_W'($urandom_range(61, 65535));
                    end
                end
            endcase
            write_reg(REG_ENTRY_COUNT, CFG_W'(cnt_val));
            write_reg(REG_DISABLE_TIMEOUT, CFG_W'(tmo_val));
            span  = span_of(cnt_val);
            // Start near the top of the time range once, to reach saturation.
            tick  = (phase == 3) ? 32'hFFFF_FF00 : t_time'($urandom);
            // Keep two phases free of sender gaps.
            quiet = (phase == 5 || phase == 6);

            for (k = 0; k < WORDS_PER_PASS; k++) begin
                if (!quiet && $urandom_range(99) < 11) begin
                    @(negedge i_clk);
                    start <= 1'b0;
                    repeat ($urandom_range(0, 19)) @(negedge i_clk);
                end
                step = t_time'($urandom_range(0, 6));
                tick = (tick > '1 - step) ? '1 : tick + step;
                now  = ($urandom_range(99) < 6) ? t_time'($urandom) : tick;
                kind = ($urandom_range(99) < 35) ? KIND_FAIL : KIND_DISPATCH;
                fe   = ($urandom_range(99) < 85) ? t_idx'($urandom_range(0, span - 1))
                                                 : t_idx'($urandom_range(0, 15));
                send_word(kind, now, fe, 1'b0, '0);
            end
        end

        // Let the last results drain, then keep the monitor running for stray words.
        settle();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d words (%0d dispatches, %0d failure reports) over %0d settings.",
                 n_words, n_dispatch, n_words - n_dispatch, PHASES + 4);
        $display("Saw %0d forced picks, %0d re-enabled picks, %0d unknown-entry reports.",
                 n_forced, n_reenabled, n_unknown);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
